// ===== src/sha1_pkg.sv =====
// Shared types, constants and helper functions of the SHA-1 hash engine.
`timescale 1ns / 1ps

package sha1_pkg;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned BYTES_W = 3;
   localparam int unsigned INDEX_W = 3;
   localparam int unsigned COUNT_W = 64;
   localparam int unsigned WIB_W   = 4;
   localparam int unsigned ROUND_W = 7;

   localparam logic [ROUND_W-1:0] LAST_ROUND = 7'd79;
   localparam logic [INDEX_W-1:0] LAST_INDEX = 3'd4;
   localparam logic [WIB_W-1:0]   WIB_FULL   = 4'd15;
   localparam logic [WIB_W-1:0]   WIB_LEN_HI = 4'd14;

   localparam logic [WORD_W-1:0] MARK_WORD = 32'h8000_0000;

   // Initial chain value, H0 in element 0.
   localparam logic [4:0][WORD_W-1:0] INIT_CHAIN = {
      32'hC3D2_E1F0, 32'h1032_5476, 32'h98BA_DCFE, 32'hEFCD_AB89, 32'h6745_2301
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_ADD,
      ST_FLUSH
   } state_type;

   typedef enum logic [2:0] {
      SEL_MSG,
      SEL_LASTPAD,
      SEL_MARK,
      SEL_ZERO,
      SEL_LEN_HI,
      SEL_LEN_LO
   } sel_type;

   typedef enum logic [1:0] {
      PH_CHOOSE,
      PH_PARITY_A,
      PH_MAJORITY,
      PH_PARITY_B
   } phase_type;

   typedef struct packed {
      logic      push;
      sel_type   push_sel;
      logic      load_work;
      logic      round_en;
      phase_type phase;
      logic      add_chain;
      logic      flush;
   } cmd_type;

   typedef struct packed {
      logic [WIB_W-1:0] wib;
      logic             out_busy;
   } status_type;

   function automatic logic [WORD_W-1:0] round_k(input phase_type ph);
      logic [WORD_W-1:0] k;
      case (ph)
         PH_CHOOSE:   k = 32'h5A82_7999;
         PH_PARITY_A: k = 32'h6ED9_EBA1;
         PH_MAJORITY: k = 32'h8F1B_BCDC;
         PH_PARITY_B: k = 32'hCA62_C1D6;
         default:     k = 32'h5A82_7999;
      endcase
      return k;
   endfunction

   function automatic logic [WORD_W-1:0] round_f(input phase_type ph,
                                                 input logic [WORD_W-1:0] b,
                                                 input logic [WORD_W-1:0] c,
                                                 input logic [WORD_W-1:0] d);
      logic [WORD_W-1:0] f;
      case (ph)
         PH_CHOOSE:   f = (b & c) | (~b & d);
         PH_MAJORITY: f = (b & c) | (b & d) | (c & d);
         default:     f = b ^ c ^ d;
      endcase
      return f;
   endfunction

endpackage

// ===== src/sha1_if.sv =====
// Valid/ready channel interfaces for message words and digest words.
`timescale 1ns / 1ps

interface sha1_req_if
   import sha1_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [WORD_W-1:0]  msg_word;
   logic [BYTES_W-1:0] word_bytes;
   logic               last_word;

   modport source (output valid, msg_word, word_bytes, last_word, input ready);
   modport sink   (input valid, msg_word, word_bytes, last_word, output ready);
endinterface

interface sha1_rsp_if
   import sha1_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [WORD_W-1:0]  digest_word;
   logic [INDEX_W-1:0] digest_index;
   logic               digest_last;

   modport source (output valid, digest_word, digest_index, digest_last, input ready);
   modport sink   (input valid, digest_word, digest_index, digest_last, output ready);
endinterface

// ===== src/sha1_ctrl.sv =====
// Controller state machine: sequences word pushes, padding, rounds and digest handoff.
`timescale 1ns / 1ps

module sha1_ctrl
   import sha1_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_last,
   input  logic [BYTES_W-1:0] req_bytes,
   output logic               req_ready,
   input  status_type         status,
   output cmd_type            cmd
);

   state_type          state_ff, state_in;
   logic [ROUND_W-1:0] round_ff, round_in;
   logic               padding_ff, padding_in;
   logic               mark_ff, mark_in;
   logic               len_hi_ff, len_hi_in;
   logic               len_done_ff, len_done_in;

   logic full_word;
   logic block_done;
   logic accept;
   sel_type pad_sel;

   assign full_word  = !req_last || (req_bytes >= 3'd4);
   assign block_done = (status.wib == WIB_FULL);
   assign accept     = (state_ff == ST_IDLE) && req_valid;

   // The low length word follows only its high half; a marker that lands in
   // the fifteenth slot is followed by zero fill and an extra block.
   always_comb begin
      if (mark_ff) begin
         pad_sel = SEL_MARK;
      end else if (status.wib == WIB_LEN_HI) begin
         pad_sel = SEL_LEN_HI;
      end else if ((status.wib == WIB_FULL) && len_hi_ff) begin
         pad_sel = SEL_LEN_LO;
      end else begin
         pad_sel = SEL_ZERO;
      end
   end

   // Next state and flags.
   always_comb begin
      state_in    = state_ff;
      round_in    = round_ff;
      padding_in  = padding_ff;
      mark_in     = mark_ff;
      len_hi_in   = len_hi_ff;
      len_done_in = len_done_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_last) begin
                  padding_in = 1'b1;
                  mark_in    = full_word;
               end
               if (block_done) begin
                  state_in = ST_ROUND;
                  round_in = '0;
               end else if (req_last) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            if (pad_sel == SEL_MARK) begin
               mark_in = 1'b0;
            end
            if (pad_sel == SEL_LEN_HI) begin
               len_hi_in = 1'b1;
            end
            if (pad_sel == SEL_LEN_LO) begin
               len_hi_in   = 1'b0;
               len_done_in = 1'b1;
            end
            if (block_done) begin
               state_in = ST_ROUND;
               round_in = '0;
            end
         end
         ST_ROUND: begin
            round_in = round_ff + 7'd1;
            if (round_ff == LAST_ROUND) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            if (len_done_ff) begin
               state_in = ST_FLUSH;
            end else if (padding_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (!status.out_busy) begin
               state_in    = ST_IDLE;
               padding_in  = 1'b0;
               len_done_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd       = '0;
      cmd.phase = PH_CHOOSE;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               cmd.push      = 1'b1;
               cmd.push_sel  = (req_last && !full_word) ? SEL_LASTPAD : SEL_MSG;
               cmd.load_work = block_done;
            end
         end
         ST_PAD: begin
            cmd.push      = 1'b1;
            cmd.push_sel  = pad_sel;
            cmd.load_work = block_done;
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
            if (round_ff < 7'd20) begin
               cmd.phase = PH_CHOOSE;
            end else if (round_ff < 7'd40) begin
               cmd.phase = PH_PARITY_A;
            end else if (round_ff < 7'd60) begin
               cmd.phase = PH_MAJORITY;
            end else begin
               cmd.phase = PH_PARITY_B;
            end
         end
         ST_ADD: begin
            cmd.add_chain = 1'b1;
         end
         ST_FLUSH: begin
            cmd.flush = !status.out_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         round_ff    <= '0;
         padding_ff  <= 1'b0;
         mark_ff     <= 1'b0;
         len_hi_ff   <= 1'b0;
         len_done_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         round_ff    <= round_in;
         padding_ff  <= padding_in;
         mark_ff     <= mark_in;
         len_hi_ff   <= len_hi_in;
         len_done_ff <= len_done_in;
      end
   end

endmodule

// ===== src/sha1_datapath.sv =====
// Datapath: schedule window, round registers, chain value, length counter and digest buffer.
`timescale 1ns / 1ps

module sha1_datapath
   import sha1_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic [WORD_W-1:0]  msg_word,
   input  logic [BYTES_W-1:0] word_bytes,
   input  logic               last_word,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [WORD_W-1:0]  out_word,
   output logic [INDEX_W-1:0] out_index,
   output logic               out_last
);

   logic [WORD_W-1:0]  win_ff [16];
   logic [WORD_W-1:0]  work_ff [5];
   logic [WORD_W-1:0]  chain_ff [5];
   logic [WORD_W-1:0]  digest_ff [5];
   logic [COUNT_W-1:0] bitcnt_ff, bitcnt_in;
   logic [WIB_W-1:0]   wib_ff, wib_in;
   logic               out_valid_ff, out_valid_in;
   logic [INDEX_W-1:0] out_idx_ff, out_idx_in;

   logic [BYTES_W-1:0] nbytes;
   logic [WORD_W-1:0]  lastpad_word;
   logic [WORD_W-1:0]  push_word;
   logic [WORD_W-1:0]  sched_x;
   logic [WORD_W-1:0]  sched_new;
   logic [WORD_W-1:0]  temp;

   // Bytes this item adds to the message.
   assign nbytes = (!last_word || word_bytes > 3'd4) ? 3'd4 : word_bytes;

   always_comb begin
      case (nbytes)
         3'd0:    lastpad_word = MARK_WORD;
         3'd1:    lastpad_word = {msg_word[31:24], 24'h80_0000};
         3'd2:    lastpad_word = {msg_word[31:16], 16'h8000};
         3'd3:    lastpad_word = {msg_word[31:8], 8'h80};
         default: lastpad_word = msg_word;
      endcase
   end

   always_comb begin
      case (cmd.push_sel)
         SEL_MSG:     push_word = msg_word;
         SEL_LASTPAD: push_word = lastpad_word;
         SEL_MARK:    push_word = MARK_WORD;
         SEL_LEN_HI:  push_word = bitcnt_ff[63:32];
         SEL_LEN_LO:  push_word = bitcnt_ff[31:0];
         default:     push_word = '0;
      endcase
   end

   // Window element 0 always holds the word of the current round.
   assign sched_x   = win_ff[13] ^ win_ff[8] ^ win_ff[2] ^ win_ff[0];
   assign sched_new = {sched_x[30:0], sched_x[31]};

   assign temp = {work_ff[0][26:0], work_ff[0][31:27]}
               + round_f(cmd.phase, work_ff[1], work_ff[2], work_ff[3])
               + work_ff[4] + round_k(cmd.phase) + win_ff[0];

   always_ff @(posedge clock) begin
      if (cmd.push || cmd.round_en) begin
         for (int i = 0; i < 15; i++) begin
            win_ff[i] <= win_ff[i+1];
         end
         win_ff[15] <= cmd.push ? push_word : sched_new;
      end
      if (cmd.load_work) begin
         for (int i = 0; i < 5; i++) begin
            work_ff[i] <= chain_ff[i];
         end
      end else if (cmd.round_en) begin
         work_ff[0] <= temp;
         work_ff[1] <= work_ff[0];
         work_ff[2] <= {work_ff[1][1:0], work_ff[1][31:2]};
         work_ff[3] <= work_ff[2];
         work_ff[4] <= work_ff[3];
      end
      if (cmd.flush) begin
         for (int i = 0; i < 5; i++) begin
            digest_ff[i] <= chain_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.flush) begin
         for (int i = 0; i < 5; i++) begin
            chain_ff[i] <= INIT_CHAIN[i];
         end
      end else if (cmd.add_chain) begin
         for (int i = 0; i < 5; i++) begin
            chain_ff[i] <= chain_ff[i] + work_ff[i];
         end
      end
   end

   always_comb begin
      bitcnt_in = bitcnt_ff;
      if (cmd.flush) begin
         bitcnt_in = '0;
      end else if (cmd.push && (cmd.push_sel == SEL_MSG || cmd.push_sel == SEL_LASTPAD)) begin
         bitcnt_in = bitcnt_ff + {58'd0, nbytes, 3'd0};
      end
      wib_in = cmd.push ? wib_ff + 4'd1 : wib_ff;
      out_valid_in = out_valid_ff;
      out_idx_in   = out_idx_ff;
      if (cmd.flush) begin
         out_valid_in = 1'b1;
         out_idx_in   = '0;
      end else if (out_valid_ff && out_ready) begin
         if (out_idx_ff == LAST_INDEX) begin
            out_valid_in = 1'b0;
         end
         out_idx_in = out_idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bitcnt_ff    <= '0;
         wib_ff       <= '0;
         out_valid_ff <= 1'b0;
         out_idx_ff   <= '0;
      end else begin
         bitcnt_ff    <= bitcnt_in;
         wib_ff       <= wib_in;
         out_valid_ff <= out_valid_in;
         out_idx_ff   <= out_idx_in;
      end
   end

   assign status.wib      = wib_ff;
   assign status.out_busy = out_valid_ff;

   assign out_valid = out_valid_ff;
   assign out_word  = digest_ff[out_idx_ff];
   assign out_index = out_idx_ff;
   assign out_last  = (out_idx_ff == LAST_INDEX);

endmodule

// ===== src/sha1_hash_engine_top.sv =====
// Top level of the SHA-1 hash engine: controller, datapath and channel wiring.
`timescale 1ns / 1ps

// The block computes the SHA-1 digest of a byte message. Message words enter
// on req_chan, big-endian, one item per word; word_bytes gives the valid bytes
// of a word marked last_word, and every other word counts as four bytes.
// Once a message ends, five digest items leave on rsp_chan in order H0 to H4,
// the fifth with digest_last set, and the engine is ready for a new message.
// A word that does not complete a 512-bit block leaves the engine ready for the
// next word. The sixteenth word of a block starts 80 rounds on the one shared
// round unit, one round a cycle, then the result is folded into the chain
// value; no word is taken meanwhile. After the last word, padding words are
// pushed one a cycle while no rounds run (up to eighteen, with one extra block
// of rounds when the length does not fit). Once the previous digest has left,
// the digest moves to the output buffer; its first item shows the next cycle.
// The digest buffer parts the two sides: a stalled receiver does not hold up
// the next message until that message's own digest is ready to be handed over.
// Synchronous reset restores the initial chain value, clears the length
// and word counters and drops any digest not yet delivered.

module sha1_hash_engine_top
   import sha1_pkg::*;
(
   input logic       clock,
   input logic       reset,
   sha1_req_if.sink   req_chan,
   sha1_rsp_if.source rsp_chan
);

   cmd_type    cmd;
   status_type status;

   // Sequences pushes, rounds and the hand-off of each finished digest.
   sha1_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last_word),
      .req_bytes (req_chan.word_bytes),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Holds the chain, round, length and word-count state and drives the digest channel.
   sha1_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .msg_word   (req_chan.msg_word),
      .word_bytes (req_chan.word_bytes),
      .last_word  (req_chan.last_word),
      .out_valid  (rsp_chan.valid),
      .out_ready  (rsp_chan.ready),
      .out_word   (rsp_chan.digest_word),
      .out_index  (rsp_chan.digest_index),
      .out_last   (rsp_chan.digest_last)
   );

endmodule

// ===== src/sha1_checker.sv =====
// Port-level checker of the SHA-1 hash engine and its bind to the top level.
`timescale 1ns / 1ps

module sha1_checker
   import sha1_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [WORD_W-1:0]  rsp_word,
   input logic [INDEX_W-1:0] rsp_index,
   input logic               rsp_last
);

   // A stalled digest item keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word) && $stable(rsp_index))
      else $error("digest item changed while stalled");

   // The final flag marks the fifth word alone.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_index == LAST_INDEX)))
      else $error("digest_last does not match digest_index");

   // Digest words follow each other with no gap and in order.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=>
         rsp_valid && (rsp_index == $past(rsp_index) + 3'd1))
      else $error("digest words out of sequence");

   // Reset leaves no digest pending and the engine ready for words.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("engine not idle after reset");

endmodule

bind sha1_hash_engine_top sha1_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_word  (rsp_chan.digest_word),
   .rsp_index (rsp_chan.digest_index),
   .rsp_last  (rsp_chan.digest_last)
);

// ===== test/sha1_hash_engine_top_tb.sv =====
// Self-checking testbench of the SHA-1 hash engine top level.
`timescale 1ns / 1ps

// Message words go in on the request channel from a queue of pending items.
// The driver and the monitor are clocked always blocks, and each one idles
// for a random number of cycles per item. Every accepted message word is fed
// to a SHA-1 model that lives in this module. When a word ends a message, the
// model pads the message, finishes the digest and queues five expected digest
// items. The monitor checks each digest item that leaves the engine against
// the oldest expected item, field by field.

module sha1_hash_engine_top_tb;
   import sha1_pkg::*;

   localparam int CLOCK_HALF  = 4;
   localparam int RESET_TICKS = 10;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_TICKS = 200;
   localparam int RANDOM_ITEMS = 280;

   // SHA-1 round constants, one for each group of twenty rounds.
   localparam logic [WORD_W-1:0] K_CHOOSE   = 32'h5A82_7999;
   localparam logic [WORD_W-1:0] K_PARITY_A = 32'h6ED9_EBA1;
   localparam logic [WORD_W-1:0] K_MAJORITY = 32'h8F1B_BCDC;
   localparam logic [WORD_W-1:0] K_PARITY_B = 32'hCA62_C1D6;

   typedef struct {
      logic [WORD_W-1:0]  msg_word;
      logic [BYTES_W-1:0] word_bytes;
      logic               last_word;
   } msg_item_type;

   typedef struct {
      logic [WORD_W-1:0]  digest_word;
      logic [INDEX_W-1:0] digest_index;
      logic               digest_last;
   } digest_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sha1_req_if req_bus ();
   sha1_rsp_if rsp_bus ();

   sha1_hash_engine_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #CLOCK_HALF clock = ~clock;

   // Items waiting to be sent, and digest items waiting to be seen.
   msg_item_type    pending[$];
   digest_item_type digest_expect[$];

   int error_count = 0;
   int cycle_count = 0;

   // State of the SHA-1 model: chain value, block buffer, word count and
   // the message length in bits.
   logic [WORD_W-1:0]  chain_h [5];
   logic [WORD_W-1:0]  block_buf [16];
   logic [WIB_W-1:0]   buf_fill;
   logic [COUNT_W-1:0] msg_bits;

   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int n);
      return (x << n) | (x >> (WORD_W - n));
   endfunction

   // Runs the 80 rounds over the full block buffer and folds the result
   // into the chain value.
   function automatic void compress_block();
      logic [WORD_W-1:0] w [16];
      logic [WORD_W-1:0] a, b, c, d, e, f, k, wr, t;
      w = block_buf;
      a = chain_h[0];
      b = chain_h[1];
      c = chain_h[2];
      d = chain_h[3];
      e = chain_h[4];
      for (int r = 0; r < 80; r++) begin
         if (r < 16) begin
            wr = w[r];
         end else begin
            wr = rotl(w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16] ^ w[r % 16], 1);
            w[r % 16] = wr;
         end
         if (r < 20) begin
            f = (b & c) | (~b & d);
            k = K_CHOOSE;
         end else if (r < 40) begin
            f = b ^ c ^ d;
            k = K_PARITY_A;
         end else if (r < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K_MAJORITY;
         end else begin
            f = b ^ c ^ d;
            k = K_PARITY_B;
         end
         t = rotl(a, 5) + f + e + k + wr;
         e = d;
         d = c;
         c = rotl(b, 30);
         b = a;
         a = t;
      end
      chain_h[0] += a;
      chain_h[1] += b;
      chain_h[2] += c;
      chain_h[3] += d;
      chain_h[4] += e;
   endfunction

   function automatic void absorb_word(input logic [WORD_W-1:0] w);
      block_buf[buf_fill] = w;
      buf_fill = buf_fill + 1'b1;
      if (buf_fill == '0) begin
         compress_block();
      end
   endfunction

   function automatic void restart_hash();
      for (int i = 0; i < 5; i++) begin
         chain_h[i] = INIT_CHAIN[i];
      end
      buf_fill = '0;
      msg_bits = '0;
   endfunction

   // Takes one accepted message word. On the last word of a message it
   // pads, finishes the digest and queues the five expected digest items.
   function automatic void predict_digest(input msg_item_type item);
      int                nbytes;
      int                sh;
      logic [WORD_W-1:0] w;
      digest_item_type   d;
      nbytes = item.word_bytes;
      // Only a last word may be short, and counts above four mean four.
      if (!item.last_word || nbytes > 4) begin
         nbytes = 4;
      end
      msg_bits += COUNT_W'(nbytes * 8);
      if (!item.last_word) begin
         absorb_word(item.msg_word);
         return;
      end
      if (nbytes == 4) begin
         absorb_word(item.msg_word);
         absorb_word(MARK_WORD);
      end else begin
         // Bytes past the count are dropped, then the marker byte follows
         // the last valid byte. An empty last word is the marker alone.
         sh = 8 * (4 - nbytes);
         w  = (nbytes == 0) ? '0 : item.msg_word & ({WORD_W{1'b1}} << sh);
         w  = w | (32'h80 << (sh - 8));
         absorb_word(w);
      end
      while (buf_fill != WIB_LEN_HI) begin
         absorb_word('0);
      end
      absorb_word(msg_bits[63:32]);
      absorb_word(msg_bits[31:0]);
      for (int i = 0; i < 5; i++) begin
         d.digest_word  = chain_h[i];
         d.digest_index = INDEX_W'(i);
         d.digest_last  = (i == 4);
         digest_expect.push_back(d);
      end
      restart_hash();
   endfunction

   // Wait before the next item. Each side switches now and then between no
   // idling at all, uniform waits and rare waits, so long stretches of each
   // kind occur.
   function automatic int draw_wait(inout int mode);
      if ($urandom_range(0, 31) == 0) begin
         mode = $urandom_range(0, 2);
      end
      case (mode)
         0: begin
            return 0;
         end
         1: begin
            return $urandom_range(0, 12);
         end
         default: begin
            return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 12) : 0;
         end
      endcase
   endfunction

   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 9))
         0: begin
            return '0;
         end
         1: begin
            return '1;
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   function automatic void queue_word(input logic [WORD_W-1:0] w, input int nbytes,
                                      input logic last);
      msg_item_type item;
      item.msg_word   = w;
      item.word_bytes = BYTES_W'(nbytes);
      item.last_word  = last;
      pending.push_back(item);
   endfunction

   // A message of n_words items. The byte counts of the words before the
   // last are random, since the engine must ignore them.
   function automatic void queue_message(input int n_words, input int last_bytes);
      for (int i = 0; i < n_words - 1; i++) begin
         queue_word(pick_word(), $urandom_range(0, 7), 1'b0);
      end
      queue_word(pick_word(), last_bytes, 1'b1);
   endfunction

   // Stimulus. The directed part covers the empty message, each short last
   // word, byte counts above four, dirty bits past the count, a short count
   // on a word that is not last, and a 56-byte message whose length does
   // not fit in its block.
   initial begin
      int planned;
      int n_words;
      restart_hash();
      queue_word(32'hFFFF_FFFF, 0, 1'b1);
      queue_word(32'hFFFF_FFFF, 1, 1'b1);
      queue_word(32'hA5C3_7E19, 2, 1'b1);
      queue_word(32'hFFFF_FFFF, 3, 1'b1);
      queue_word(32'h0000_0000, 4, 1'b1);
      queue_word(32'h6162_6364, 5, 1'b1);
      queue_word(32'h0000_0000, 6, 1'b1);
      queue_word(32'hFFFF_FFFF, 7, 1'b1);
      queue_word(32'hFFFF_FFFF, 1, 1'b0);
      queue_word(32'h1234_5678, 0, 1'b1);
      queue_message(14, 4);

      // Random messages. Many lengths lie near a block boundary, where the
      // padding may need an extra block.
      planned = 0;
      while (planned < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: n_words = $urandom_range(1, 8);
            5, 6, 7:       n_words = $urandom_range(13, 17);
            8:             n_words = $urandom_range(29, 33);
            default:       n_words = $urandom_range(1, 48);
         endcase
         queue_message(n_words, $urandom_range(0, 7));
         planned += n_words;
      end
   end

   // Inputs are known from time zero; reset is held for a fixed stretch.
   initial begin
      req_bus.valid      = 1'b0;
      req_bus.msg_word   = '0;
      req_bus.word_bytes = '0;
      req_bus.last_word  = 1'b0;
      rsp_bus.ready      = 1'b0;
      repeat (RESET_TICKS) @(posedge clock);
      reset <= 1'b0;
   end

   // Driver. An item that was accepted at this edge goes to the model; a
   // free slot takes the next pending item once its wait has run out.
   msg_item_type send_item;
   int           send_wait = 0;
   int           send_mode = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_digest(send_item);
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_wait > 0) begin
               send_wait--;
               req_bus.valid <= 1'b0;
            end else if (pending.size() > 0) begin
               send_item = pending.pop_front();
               req_bus.valid      <= 1'b1;
               req_bus.msg_word   <= send_item.msg_word;
               req_bus.word_bytes <= send_item.word_bytes;
               req_bus.last_word  <= send_item.last_word;
               send_wait = draw_wait(send_mode);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor. Each digest item is checked against the oldest expected one,
   // then ready stays low for a random number of cycles.
   digest_item_type want;
   int              recv_wait = 0;
   int              recv_mode = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (digest_expect.size() == 0) begin
               $error("unexpected digest item: digest_index %0d digest_word %h",
                      rsp_bus.digest_index, rsp_bus.digest_word);
               error_count++;
            end else begin
               want = digest_expect.pop_front();
               if (rsp_bus.digest_word !== want.digest_word) begin
                  $error("digest_word: expected %h, actual %h",
                         want.digest_word, rsp_bus.digest_word);
                  error_count++;
               end
               if (rsp_bus.digest_index !== want.digest_index) begin
                  $error("digest_index: expected %0d, actual %0d",
                         want.digest_index, rsp_bus.digest_index);
                  error_count++;
               end
               if (rsp_bus.digest_last !== want.digest_last) begin
                  $error("digest_last: expected %0d, actual %0d",
                         want.digest_last, rsp_bus.digest_last);
                  error_count++;
               end
            end
            recv_wait = draw_wait(recv_mode);
         end
         if (recv_wait > 0) begin
            recv_wait--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // End of the run. Queues are inspected on the falling edge, after the
   // clocked blocks have settled.
   initial begin
      @(negedge clock);
      while (reset || pending.size() > 0 || req_bus.valid || digest_expect.size() > 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_TICKS) @(posedge clock);
      if (error_count == 0) begin
         $display("sha1_hash_engine_top_tb: PASS");
      end else begin
         $display("sha1_hash_engine_top_tb: FAIL");
      end
      $finish;
   end

   // Timeout: a hung handshake ends the run as a failure.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("sha1_hash_engine_top_tb: FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
src/sha1_pkg.sv
src/sha1_if.sv
src/sha1_ctrl.sv
src/sha1_datapath.sv
src/sha1_hash_engine_top.sv
src/sha1_checker.sv
test/sha1_hash_engine_top_tb.sv
